[sv/idp_pkg.sv]
// Shared types, character codes and constants of the ISO 8601 date-time parser.
package idp_pkg;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_DIGIT  = 3'd1,
        ST_COLON  = 3'd2,
        ST_FRAC   = 3'd3,
        ST_SIGN   = 3'd4
    } status_t;

    localparam logic [7:0]  CH_DASH   = 8'h2D;
    localparam logic [7:0]  CH_PLUS   = 8'h2B;
    localparam logic [7:0]  CH_T      = 8'h54;
    localparam logic [7:0]  CH_COLON  = 8'h3A;
    localparam logic [7:0]  CH_DOT    = 8'h2E;
    localparam logic [7:0]  CH_Z      = 8'h5A;
    localparam logic [7:0]  CH_ZERO   = 8'h30;
    localparam logic [7:0]  CH_NINE   = 8'h39;

    localparam logic [13:0] YEAR_BASE     = 14'd1900;
    localparam logic [7:0]  LEN_MAX       = 8'd255;
    localparam logic [3:0]  FRAC_DIGITS   = 4'd9;

    // weight of a fraction digit in nanoseconds, by its place after the point
    function automatic logic [26:0] frac_weight(input logic [3:0] idx);
        logic [26:0] w;
        case (idx)
            4'd0:    w = 27'd100000000;
            4'd1:    w = 27'd10000000;
            4'd2:    w = 27'd1000000;
            4'd3:    w = 27'd100000;
            4'd4:    w = 27'd10000;
            4'd5:    w = 27'd1000;
            4'd6:    w = 27'd100;
            4'd7:    w = 27'd10;
            4'd8:    w = 27'd1;
            default: w = 27'd0;
        endcase
        return w;
    endfunction

endpackage

[sv/iso8601_datetime_parser_core.sv]
// ISO 8601 date-time parser: one character per beat, one result per string.
//
// Takes one character per input beat and parses YYYY[-MM[-DD[THH:MM[:SS[.f...]]zone]]],
// where zone is Z or a sign, HH, an optional colon and MM. A beat with first set
// restarts the parse with that character. The phase machine and the field
// accumulators update in the cycle the beat is accepted, and a result, when the
// string completes or fails, lands in the output register at the same edge, so a
// new character can be taken every cycle while in_ready is high. The output register
// is one deep; in_ready drops only while a result is held and out_ready is low.
// Characters after a result are ignored until the next beat marked first.
module iso8601_datetime_parser_core
    import idp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         character,
    input  logic               first,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [13:0] year_offset,
    output logic signed [7:0]  month_index,
    output logic [6:0]         day,
    output logic [6:0]         hour,
    output logic [6:0]         minute,
    output logic [6:0]         second,
    output logic [29:0]        nanoseconds,
    output logic signed [1:0]  zone_sign,
    output logic [6:0]         zone_hours,
    output logic [6:0]         zone_minutes,
    output logic [2:0]         status,
    output logic [7:0]         consumed_length
);

    typedef enum logic [4:0] {
        PH_YEAR         = 5'd0,
        PH_AFTER_YEAR   = 5'd1,
        PH_MONTH        = 5'd2,
        PH_AFTER_MONTH  = 5'd3,
        PH_DAY          = 5'd4,
        PH_AFTER_DAY    = 5'd5,
        PH_HOUR         = 5'd6,
        PH_HOUR_COLON   = 5'd7,
        PH_MINUTE       = 5'd8,
        PH_AFTER_MINUTE = 5'd9,
        PH_SECOND       = 5'd10,
        PH_AFTER_SECOND = 5'd11,
        PH_FRAC_FIRST   = 5'd12,
        PH_FRAC         = 5'd13,
        PH_ZONE_HOUR    = 5'd14,
        PH_ZONE_COLON   = 5'd15,
        PH_ZONE_MIN     = 5'd16,
        PH_DONE         = 5'd17
    } phase_t;

    logic        active_reg,  active_next;
    phase_t      phase_reg,   phase_next;
    logic [3:0]  dpos_reg,    dpos_next;
    logic [13:0] year_reg,    year_next;
    logic [6:0]  month_reg,   month_next;
    logic [6:0]  day_reg,     day_next;
    logic [6:0]  hour_reg,    hour_next;
    logic [6:0]  min_reg,     min_next;
    logic [6:0]  sec_reg,     sec_next;
    logic [29:0] frac_reg,    frac_next;
    logic [3:0]  fidx_reg,    fidx_next;
    logic [1:0]  sign_reg,    sign_next;
    logic [6:0]  zh_reg,      zh_next;
    logic [6:0]  zm_reg,      zm_next;
    logic [7:0]  len_reg,     len_next;

    logic        out_valid_reg, out_valid_next;
    logic [13:0] year_out_reg,  year_out_next;
    logic [7:0]  month_out_reg, month_out_next;
    logic [6:0]  day_out_reg,   day_out_next;
    logic [6:0]  hour_out_reg,  hour_out_next;
    logic [6:0]  min_out_reg,   min_out_next;
    logic [6:0]  sec_out_reg,   sec_out_next;
    logic [29:0] frac_out_reg,  frac_out_next;
    logic [1:0]  sign_out_reg,  sign_out_next;
    logic [6:0]  zh_out_reg,    zh_out_next;
    logic [6:0]  zm_out_reg,    zm_out_next;
    status_t     st_out_reg,    st_out_next;
    logic [7:0]  len_out_reg,   len_out_next;

    logic        accept;
    logic        is_dig;
    logic [3:0]  dval;
    logic        emit;
    status_t     st;
    logic        take;
    logic        dig_phase;
    logic [13:0] acc_cur;
    logic [13:0] acc_prod;
    logic [3:0]  dpos_last;
    phase_t      dig_done_phase;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign is_dig   = (character >= CH_ZERO) && (character <= CH_NINE);
    assign dval     = character[3:0];

    always_comb
    begin
        active_next = active_reg;
        phase_next  = phase_reg;
        dpos_next   = dpos_reg;
        year_next   = year_reg;
        month_next  = month_reg;
        day_next    = day_reg;
        hour_next   = hour_reg;
        min_next    = min_reg;
        sec_next    = sec_reg;
        frac_next   = frac_reg;
        fidx_next   = fidx_reg;
        sign_next   = sign_reg;
        zh_next     = zh_reg;
        zm_next     = zm_reg;
        len_next    = len_reg;
        emit        = 1'b0;
        st          = ST_OK;
        take        = 1'b0;

        // restart on a first beat
        if (accept && first)
        begin
            active_next = 1'b1;
            phase_next  = PH_YEAR;
            dpos_next   = 4'd0;
            year_next   = 14'd0;
            month_next  = 7'd0;
            day_next    = 7'd1;
            hour_next   = 7'd0;
            min_next    = 7'd0;
            sec_next    = 7'd0;
            frac_next   = 30'd0;
            fidx_next   = 4'd0;
            sign_next   = 2'sd0;
            zh_next     = 7'd0;
            zm_next     = 7'd0;
            len_next    = 8'd0;
        end

        dig_phase      = 1'b1;
        acc_cur        = 14'd0;
        dpos_last      = 4'd1;
        dig_done_phase = PH_DONE;
        case (phase_next)
            PH_YEAR:
            begin
                acc_cur        = year_next;
                dpos_last      = 4'd3;
                dig_done_phase = PH_AFTER_YEAR;
            end
            PH_MONTH:
            begin
                acc_cur        = {7'd0, month_next};
                dig_done_phase = PH_AFTER_MONTH;
            end
            PH_DAY:
            begin
                acc_cur        = {7'd0, day_next};
                dig_done_phase = PH_AFTER_DAY;
            end
            PH_HOUR:
            begin
                acc_cur        = {7'd0, hour_next};
                dig_done_phase = PH_HOUR_COLON;
            end
            PH_MINUTE:
            begin
                acc_cur        = {7'd0, min_next};
                dig_done_phase = PH_AFTER_MINUTE;
            end
            PH_SECOND:
            begin
                acc_cur        = {7'd0, sec_next};
                dig_done_phase = PH_AFTER_SECOND;
            end
            PH_ZONE_HOUR:
            begin
                acc_cur        = {7'd0, zh_next};
                dig_done_phase = PH_ZONE_COLON;
            end
            PH_ZONE_MIN, PH_ZONE_COLON:
            begin
                acc_cur        = {7'd0, zm_next};
                dig_done_phase = PH_DONE;
            end
            default:
            begin
                dig_phase = 1'b0;
            end
        endcase
        acc_prod = 14'(acc_cur * 14'd10) + {10'd0, dval};

        if (accept && (first || active_reg))
        begin
            if (dig_phase && phase_next != PH_ZONE_COLON)
            begin
                if (!is_dig)
                begin
                    emit = 1'b1;
                    st   = ST_DIGIT;
                end
                else
                begin
                    take = 1'b1;
                    case (phase_next)
                        PH_YEAR:      year_next  = acc_prod;
                        PH_MONTH:     month_next = acc_prod[6:0];
                        PH_DAY:       day_next   = acc_prod[6:0];
                        PH_HOUR:      hour_next  = acc_prod[6:0];
                        PH_MINUTE:    min_next   = acc_prod[6:0];
                        PH_SECOND:    sec_next   = acc_prod[6:0];
                        PH_ZONE_HOUR: zh_next    = acc_prod[6:0];
                        default:      zm_next    = acc_prod[6:0];
                    endcase
                    if (dpos_next == dpos_last)
                    begin
                        dpos_next  = 4'd0;
                        phase_next = dig_done_phase;
                        if (dig_done_phase == PH_DONE)
                        begin
                            emit = 1'b1;
                        end
                    end
                    else
                    begin
                        dpos_next = dpos_next + 4'd1;
                    end
                end
            end
            else
            begin
                case (phase_next)
                    PH_AFTER_YEAR:
                    begin
                        if (character == CH_DASH)
                        begin
                            take       = 1'b1;
                            phase_next = PH_MONTH;
                            dpos_next  = 4'd0;
                        end
                        else
                        begin
                            emit = 1'b1;
                        end
                    end
                    PH_AFTER_MONTH:
                    begin
                        if (character == CH_DASH)
                        begin
                            take       = 1'b1;
                            phase_next = PH_DAY;
                            dpos_next  = 4'd0;
                            day_next   = 7'd0;
                        end
                        else
                        begin
                            emit = 1'b1;
                        end
                    end
                    PH_AFTER_DAY:
                    begin
                        if (character == CH_T)
                        begin
                            take       = 1'b1;
                            phase_next = PH_HOUR;
                            dpos_next  = 4'd0;
                        end
                        else
                        begin
                            emit = 1'b1;
                        end
                    end
                    PH_HOUR_COLON:
                    begin
                        if (character == CH_COLON)
                        begin
                            take       = 1'b1;
                            phase_next = PH_MINUTE;
                            dpos_next  = 4'd0;
                        end
                        else
                        begin
                            emit = 1'b1;
                            st   = ST_COLON;
                        end
                    end
                    PH_FRAC_FIRST:
                    begin
                        if (is_dig)
                        begin
                            take       = 1'b1;
                            phase_next = PH_FRAC;
                            dpos_next  = 4'd0;
                        end
                        else
                        begin
                            emit = 1'b1;
                            st   = ST_FRAC;
                        end
                    end
                    PH_ZONE_COLON:
                    begin
                        take       = 1'b1;
                        phase_next = PH_ZONE_MIN;
                        if (character != CH_COLON)
                        begin
                            if (is_dig)
                            begin
                                zm_next   = acc_prod[6:0];
                                dpos_next = 4'd1;
                            end
                            else
                            begin
                                take = 1'b0;
                                emit = 1'b1;
                                st   = ST_DIGIT;
                            end
                        end
                    end
                    PH_AFTER_MINUTE, PH_AFTER_SECOND, PH_FRAC:
                    begin
                        if (phase_next == PH_AFTER_MINUTE && character == CH_COLON)
                        begin
                            take       = 1'b1;
                            phase_next = PH_SECOND;
                            dpos_next  = 4'd0;
                        end
                        else if (phase_next == PH_AFTER_SECOND && character == CH_DOT)
                        begin
                            take       = 1'b1;
                            phase_next = PH_FRAC_FIRST;
                            dpos_next  = 4'd0;
                        end
                        else if (phase_next == PH_FRAC && is_dig)
                        begin
                            take = 1'b1;
                        end
                        else if (character == CH_Z)
                        begin
                            take = 1'b1;
                            emit = 1'b1;
                        end
                        else if (character == CH_PLUS || character == CH_DASH)
                        begin
                            take       = 1'b1;
                            sign_next  = (character == CH_PLUS) ? 2'b01 : 2'b11;
                            phase_next = PH_ZONE_HOUR;
                            dpos_next  = 4'd0;
                        end
                        else
                        begin
                            emit = 1'b1;
                            st   = ST_SIGN;
                        end
                    end
                    default:
                    begin
                        emit = 1'b1;
                    end
                endcase

                // accumulate a fraction digit, drop those past the ninth
                if (take && is_dig && (phase_next == PH_FRAC)
                    && (phase_reg == PH_FRAC_FIRST || phase_reg == PH_FRAC || first == 1'b0)
                    && fidx_next < FRAC_DIGITS)
                begin
                    frac_next = frac_next + 30'(32'(dval) * 32'(frac_weight(fidx_next)));
                    fidx_next = fidx_next + 4'd1;
                end
            end

            if (take && len_next != LEN_MAX)
            begin
                len_next = len_next + 8'd1;
            end
            if (emit)
            begin
                active_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        year_out_next  = year_out_reg;
        month_out_next = month_out_reg;
        day_out_next   = day_out_reg;
        hour_out_next  = hour_out_reg;
        min_out_next   = min_out_reg;
        sec_out_next   = sec_out_reg;
        frac_out_next  = frac_out_reg;
        sign_out_next  = sign_out_reg;
        zh_out_next    = zh_out_reg;
        zm_out_next    = zm_out_reg;
        st_out_next    = st_out_reg;
        len_out_next   = len_out_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            st_out_next    = st;
            len_out_next   = len_next;
            if (st == ST_OK)
            begin
                year_out_next  = year_next - YEAR_BASE;
                month_out_next = (phase_next >= PH_AFTER_MONTH)
                                 ? ({1'b0, month_next} - 8'd1) : 8'd0;
                day_out_next   = day_next;
                hour_out_next  = hour_next;
                min_out_next   = min_next;
                sec_out_next   = sec_next;
                frac_out_next  = frac_next;
                sign_out_next  = sign_next;
                zh_out_next    = zh_next;
                zm_out_next    = zm_next;
            end
            else
            begin
                year_out_next  = 14'd0;
                month_out_next = 8'd0;
                day_out_next   = 7'd0;
                hour_out_next  = 7'd0;
                min_out_next   = 7'd0;
                sec_out_next   = 7'd0;
                frac_out_next  = 30'd0;
                sign_out_next  = 2'd0;
                zh_out_next    = 7'd0;
                zm_out_next    = 7'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            phase_reg     <= PH_YEAR;
            dpos_reg      <= 4'd0;
            year_reg      <= 14'd0;
            month_reg     <= 7'd0;
            day_reg       <= 7'd1;
            hour_reg      <= 7'd0;
            min_reg       <= 7'd0;
            sec_reg       <= 7'd0;
            frac_reg      <= 30'd0;
            fidx_reg      <= 4'd0;
            sign_reg      <= 2'd0;
            zh_reg        <= 7'd0;
            zm_reg        <= 7'd0;
            len_reg       <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            phase_reg     <= phase_next;
            dpos_reg      <= dpos_next;
            year_reg      <= year_next;
            month_reg     <= month_next;
            day_reg       <= day_next;
            hour_reg      <= hour_next;
            min_reg       <= min_next;
            sec_reg       <= sec_next;
            frac_reg      <= frac_next;
            fidx_reg      <= fidx_next;
            sign_reg      <= sign_next;
            zh_reg        <= zh_next;
            zm_reg        <= zm_next;
            len_reg       <= len_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        year_out_reg  <= year_out_next;
        month_out_reg <= month_out_next;
        day_out_reg   <= day_out_next;
        hour_out_reg  <= hour_out_next;
        min_out_reg   <= min_out_next;
        sec_out_reg   <= sec_out_next;
        frac_out_reg  <= frac_out_next;
        sign_out_reg  <= sign_out_next;
        zh_out_reg    <= zh_out_next;
        zm_out_reg    <= zm_out_next;
        st_out_reg    <= st_out_next;
        len_out_reg   <= len_out_next;
    end

    assign out_valid       = out_valid_reg;
    assign year_offset     = $signed(year_out_reg);
    assign month_index     = $signed(month_out_reg);
    assign day             = day_out_reg;
    assign hour            = hour_out_reg;
    assign minute          = min_out_reg;
    assign second          = sec_out_reg;
    assign nanoseconds     = frac_out_reg;
    assign zone_sign       = $signed(sign_out_reg);
    assign zone_hours      = zh_out_reg;
    assign zone_minutes    = zm_out_reg;
    assign status          = st_out_reg;
    assign consumed_length = len_out_reg;

endmodule
